// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file.
// No dependencies; each file that asserts includes this header once.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain clocked property, disabled while reset is held
`define GMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define GMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  `GMC_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ----- sv/gmc_pkg.sv -----
// Shared types and constants for the global minimum cut block.
// No dependencies; used by the top level and the checker.
package gmc_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int IDX_W            = 4;
  localparam int WEIGHT_W         = 8;
  localparam int OUT_W            = 16;
  localparam int VC_W             = 5;
  localparam logic [VC_W-1:0] VC_RESET = 5'd16;

  // Control sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_LOAD,
    ST_START,
    ST_PHASE,
    ST_SWEEP,
    ST_DECIDE,
    ST_EMIT
  } gmc_state_t;

  // What a sweep over the vertices does
  typedef enum logic [1:0] {
    SW_INIT,
    SW_ADD,
    SW_MERGE
  } sweep_kind_t;

endpackage

// ----- sv/gmc_adj_ram.sv -----
// Adjacency store: one write port, two registered read ports.
// Depends on nothing; instantiated by global_min_cut.
module gmc_adj_ram #(
  parameter int AW = 8,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic [AW-1:0] rd_a_addr,
  input  logic [AW-1:0] rd_b_addr,
  output logic [DW-1:0] rd_a_data,
  output logic [DW-1:0] rd_b_data
);

  logic [DW-1:0] mem [2**AW];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read ports, registered
  always_ff @(posedge clk) begin
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule

// ----- sv/global_min_cut.sv -----
// Edge beats load at one per cycle while in_ready is high; a beat marked final
// starts the cut search. The search runs as per-vertex sweeps through the
// adjacency RAM. Then a clearing pass over every entry wipes the store; the
// same pass runs after reset. No input is taken while busy. The result beat
// is raised once the search ends and any earlier result has been taken.
module global_min_cut #(
  parameter int MAX_VERTICES = gmc_pkg::MAX_VERTICES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [gmc_pkg::VC_W-1:0]      cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [gmc_pkg::IDX_W-1:0]     in_row_vertex,
  input  logic [gmc_pkg::IDX_W-1:0]     in_col_vertex,
  input  logic [gmc_pkg::WEIGHT_W-1:0]  in_edge_weight,
  input  logic                          in_is_final,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [gmc_pkg::OUT_W-1:0]     out_cut_weight,
  output logic [gmc_pkg::OUT_W-1:0]     out_side_mask
);
  import gmc_pkg::*;

  localparam int IW = $clog2(MAX_VERTICES);
  localparam int NW = IW + 1;
  localparam int KW = 2 * IW;
  localparam int AW = WEIGHT_W + KW;
  localparam int CW = (AW > OUT_W) ? AW : OUT_W;

  // symmetric matrix: only the entry {min, max} is kept
  function automatic logic [KW-1:0] adj_key(input logic [IW-1:0] a, input logic [IW-1:0] b);
    if (a < b) adj_key = {a, b};
    else       adj_key = {b, a};
  endfunction

  gmc_state_t  state_r, state_nxt;
  sweep_kind_t kind_r;

  logic [VC_W-1:0]         vc_r;
  logic [KW-1:0]           clr_cnt_r;
  logic [NW-1:0]           n_r, n_w;
  logic [NW-1:0]           phase_r, i_r;
  logic [IW-1:0]           last_r, prev_r, pick_r;
  logic [AW-1:0]           pick_val_r;
  logic                    found_r;
  logic [IW-1:0]           sw_j_r, pj_r;
  logic                    sw_iss_r, pv_r;
  logic                    diag_a_r, diag_b_r;
  logic [MAX_VERTICES-1:0] merged_r, added_r;
  logic                    best_valid_r;
  logic [AW-1:0]           best_w_r;
  logic [MAX_VERTICES-1:0] best_mask_r;
  logic                    out_valid_r;
  logic [OUT_W-1:0]        out_cw_r, out_sm_r;

  // attach sums and merged groups live in small RAMs
  logic [AW-1:0]           att_mem [MAX_VERTICES];
  logic [AW-1:0]           att_q_r;
  logic [MAX_VERTICES-1:0] grp_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] grp_a_q_r, grp_b_q_r;

  logic          in_fire, edge_ok;
  logic [IW-1:0] row_a, row_b;
  logic          issue_last, sweep_done, is_merge_step, better, cand;
  logic [AW-1:0] rd_a, rd_b, a_val, b_val, new_att, merge_sum;
  logic          adj_we;
  logic [KW-1:0] adj_wa;
  logic [AW-1:0] adj_wd;
  logic [CW-1:0] cw_ext;

  gmc_adj_ram #(.AW(KW), .DW(AW)) u_adj_ram (
    .clk       (clk),
    .wr_en     (adj_we),
    .wr_addr   (adj_wa),
    .wr_data   (adj_wd),
    .rd_a_addr (adj_key(row_a, sw_j_r)),
    .rd_b_addr (adj_key(row_b, sw_j_r)),
    .rd_a_data (rd_a),
    .rd_b_data (rd_b)
  );

  // vertex count clamped to the built range
  always_comb begin
    if (vc_r < VC_W'(2))                      n_w = NW'(2);
    else if (32'(vc_r) > MAX_VERTICES)        n_w = NW'(MAX_VERTICES);
    else                                      n_w = NW'(vc_r);
  end

  // sweep datapath
  assign in_fire       = in_valid && in_ready;
  assign edge_ok       = (in_row_vertex != in_col_vertex)
                         && (32'(in_row_vertex) < MAX_VERTICES)
                         && (32'(in_col_vertex) < MAX_VERTICES);
  assign row_a         = (kind_r == SW_MERGE) ? prev_r : last_r;
  assign row_b         = last_r;
  assign issue_last    = ({1'b0, sw_j_r} == n_r - NW'(1));
  assign sweep_done    = pv_r && ({1'b0, pj_r} == n_r - NW'(1));
  assign a_val         = diag_a_r ? '0 : rd_a;
  assign b_val         = diag_b_r ? '0 : rd_b;
  assign new_att       = (kind_r == SW_ADD) ? (att_q_r + a_val) : a_val;
  assign merge_sum     = a_val + b_val;
  assign cand          = (pj_r != '0) && !added_r[pj_r]
                         && (!found_r || (new_att > pick_val_r));
  assign is_merge_step = (i_r == phase_r - NW'(1));
  assign better        = !best_valid_r || (pick_val_r < best_w_r);
  assign cw_ext        = best_valid_r ? CW'(best_w_r) : '0;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (&clr_cnt_r) state_nxt = ST_LOAD;
      ST_LOAD:   if (in_fire && in_is_final) state_nxt = ST_START;
      ST_START:  state_nxt = ST_PHASE;
      ST_PHASE:  state_nxt = ST_SWEEP;
      ST_DECIDE: state_nxt = ST_SWEEP;
      ST_SWEEP: begin
        if (sweep_done) begin
          if (kind_r != SW_MERGE)    state_nxt = ST_DECIDE;
          else if (phase_r == NW'(1)) state_nxt = ST_EMIT;
          else                       state_nxt = ST_PHASE;
        end
      end
      ST_EMIT:   if (!out_valid_r) state_nxt = ST_CLEAR;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  // outputs and adjacency write port
  always_comb begin
    in_ready = (state_r == ST_LOAD);
    adj_we   = 1'b0;
    adj_wa   = clr_cnt_r;
    adj_wd   = '0;
    unique case (state_r)
      ST_CLEAR: adj_we = 1'b1;
      ST_LOAD: begin
        adj_we = in_fire && edge_ok;
        adj_wa = adj_key(IW'(in_row_vertex), IW'(in_col_vertex));
        adj_wd = AW'(in_edge_weight);
      end
      ST_SWEEP: begin
        adj_we = pv_r && (kind_r == SW_MERGE) && (pj_r != prev_r);
        adj_wa = adj_key(prev_r, pj_r);
        adj_wd = merge_sum;
      end
      default: ;
    endcase
  end

  assign out_valid      = out_valid_r;
  assign out_cut_weight = out_cw_r;
  assign out_side_mask  = out_sm_r;

  // attach and group RAMs
  always_ff @(posedge clk) begin
    if (state_r == ST_SWEEP && pv_r && kind_r != SW_MERGE) begin
      att_mem[pj_r] <= new_att;
    end
    att_q_r <= att_mem[sw_j_r];
    if (state_r == ST_CLEAR && 32'(clr_cnt_r) < MAX_VERTICES) begin
      grp_mem[clr_cnt_r[IW-1:0]] <= MAX_VERTICES'(1) << clr_cnt_r[IW-1:0];
    end else if (state_r == ST_SWEEP && sweep_done && kind_r == SW_MERGE) begin
      grp_mem[prev_r] <= grp_a_q_r | grp_b_q_r;
    end
    grp_a_q_r <= grp_mem[prev_r];
    grp_b_q_r <= grp_mem[last_r];
  end

  // payload registers
  always_ff @(posedge clk) begin
    // pipeline of the sweep
    pj_r     <= sw_j_r;
    diag_a_r <= (row_a == sw_j_r);
    diag_b_r <= (row_b == sw_j_r);
    if (state_r == ST_SWEEP && pv_r && kind_r != SW_MERGE && cand) begin
      pick_r     <= pj_r;
      pick_val_r <= new_att;
    end
    if (state_r == ST_SWEEP && sweep_done && kind_r == SW_MERGE && better) begin
      best_w_r    <= pick_val_r;
      best_mask_r <= grp_b_q_r;
    end
    if (state_r == ST_EMIT && !out_valid_r) begin
      out_cw_r <= (cw_ext > CW'(16'hFFFF)) ? 16'hFFFF : cw_ext[OUT_W-1:0];
      out_sm_r <= OUT_W'(best_mask_r);
    end
    if (state_r == ST_START) begin
      n_r <= n_w;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      vc_r         <= VC_RESET;
      clr_cnt_r    <= '0;
      kind_r       <= SW_INIT;
      phase_r      <= '0;
      i_r          <= '0;
      last_r       <= '0;
      prev_r       <= '0;
      found_r      <= 1'b0;
      sw_j_r       <= '0;
      sw_iss_r     <= 1'b0;
      pv_r         <= 1'b0;
      merged_r     <= '0;
      added_r      <= '0;
      best_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) vc_r <= cfg_wr_data;
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;

      case (state_r)
        ST_CLEAR: clr_cnt_r <= clr_cnt_r + 1'b1;
        ST_START: phase_r <= n_w - NW'(1);
        ST_PHASE: begin
          added_r  <= merged_r;
          i_r      <= '0;
          last_r   <= '0;
          kind_r   <= SW_INIT;
          sw_j_r   <= '0;
          sw_iss_r <= 1'b1;
          found_r  <= 1'b0;
          pv_r     <= 1'b0;
        end
        ST_DECIDE: begin
          last_r <= pick_r;
          if (is_merge_step) begin
            prev_r <= last_r;
            kind_r <= SW_MERGE;
          end else begin
            added_r[pick_r] <= 1'b1;
            i_r             <= i_r + NW'(1);
            kind_r          <= SW_ADD;
          end
          sw_j_r   <= '0;
          sw_iss_r <= 1'b1;
          found_r  <= 1'b0;
          pv_r     <= 1'b0;
        end
        ST_SWEEP: begin
          pv_r <= sw_iss_r;
          if (sw_iss_r) begin
            sw_j_r <= sw_j_r + IW'(1);
            if (issue_last) sw_iss_r <= 1'b0;
          end
          if (pv_r && kind_r != SW_MERGE && cand) found_r <= 1'b1;
          if (sweep_done && kind_r == SW_MERGE) begin
            merged_r[last_r] <= 1'b1;
            phase_r          <= phase_r - NW'(1);
            if (better) best_valid_r <= 1'b1;
          end
        end
        ST_EMIT: begin
          if (!out_valid_r) begin
            out_valid_r  <= 1'b1;
            merged_r     <= '0;
            best_valid_r <= 1'b0;
            clr_cnt_r    <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ----- sv/gmc_checker.sv -----
// Port-level checks for global_min_cut, bound to every instance.
// Depends on gmc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gmc_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      in_is_final,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [gmc_pkg::OUT_W-1:0] out_cut_weight,
  input logic [gmc_pkg::OUT_W-1:0] out_side_mask
);

  // a stalled result beat holds
  `GMC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_cut_weight) && $stable(out_side_mask), "result beat changed while stalled")

  // the final edge beat starts the search, so loading stops
  `GMC_ASSERT_NEXT(a_final_busy, in_valid && in_ready && in_is_final, !in_ready, "input still ready after final edge")

  // one result per graph, never two in a row
  `GMC_ASSERT_NEXT(a_one_result, out_valid && out_ready, !out_valid, "second result straight after the first")

endmodule

bind global_min_cut gmc_checker u_gmc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_is_final    (in_is_final),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_cut_weight (out_cut_weight),
  .out_side_mask  (out_side_mask)
);
